### rtl/core/skyline_rect_packer_core_macros.svh
// assertion macros for the skyline packer
`ifndef SKYLINE_RECT_PACKER_CORE_MACROS_SVH
`define SKYLINE_RECT_PACKER_CORE_MACROS_SVH

// plain property checked on every clock edge out of reset
`define SKYRP_CHECK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// implication that holds in the same cycle
`define SKYRP_IMPLY(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// implication whose consequent holds in the next cycle
`define SKYRP_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

### rtl/core/skyrp_pkg.sv
// shared types and constants of the skyline packer
`default_nettype none
package skyrp_pkg;
	localparam int MAX_NODES  = 256;
	localparam int IDX_BITS   = $clog2(MAX_NODES + 1);
	localparam int ADDR_BITS  = $clog2(MAX_NODES);
	localparam int COORD_BITS = 16;

	typedef enum logic [1:0] {
		REG_CANVAS_W = 2'd0,
		REG_CANVAS_H = 2'd1,
		REG_ALIGN    = 2'd2,
		REG_MODE     = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [COORD_BITS-1:0] x;
		logic [COORD_BITS-1:0] y;
	} edge_t;

	typedef struct packed {
		logic                 rd_en;
		logic [ADDR_BITS-1:0] rd_addr;
		logic                 wr_en;
		logic [ADDR_BITS-1:0] wr_addr;
		edge_t                wr_data;
		logic                 clr;
	} mem_req_t;
endpackage
`default_nettype wire

### rtl/core/skyrp_mem.sv
// skyline edge store, one write and one registered read per cycle
`default_nettype none
module skyrp_mem
	import skyrp_pkg::*;
(
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire mem_req_t req,
	output edge_t         rd_data
);
	edge_t mem [MAX_NODES];
	edge_t rd_q;
	logic  e0_valid_q;
	logic  rd_zero_q;

	always_ff @(posedge clk) begin
		if (req.wr_en) begin
			mem[req.wr_addr] <= req.wr_data;
		end
		if (req.rd_en) begin
			rd_q <= mem[req.rd_addr];
		end
	end

	// entry 0 reads as the origin edge until it is written after a clear
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			e0_valid_q <= 1'b0;
			rd_zero_q  <= 1'b0;
		end else begin
			if (req.clr) begin
				e0_valid_q <= 1'b0;
			end else if (req.wr_en && req.wr_addr == '0) begin
				e0_valid_q <= 1'b1;
			end
			if (req.rd_en) begin
				rd_zero_q <= (req.rd_addr == '0) && !e0_valid_q;
			end
		end
	end

	assign rd_data = rd_zero_q ? '0 : rd_q;
endmodule
`default_nettype wire

### rtl/core/skyrp_div.sv
// restoring divider, one quotient bit per cycle
`default_nettype none
module skyrp_div
	import skyrp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  start,
	input  wire logic [COORD_BITS:0]   num,
	input  wire logic [COORD_BITS-1:0] den,
	output logic                       done,
	output logic [COORD_BITS:0]        quo
);
	localparam int NBITS = COORD_BITS + 1;
	localparam int CBITS = $clog2(NBITS + 1);

	logic [COORD_BITS-1:0] rem_q;
	logic [COORD_BITS:0]   quo_q;
	logic [CBITS-1:0]      cnt_q;
	logic                  run_q;
	logic                  done_q;
	logic [COORD_BITS:0]   trial;

	assign trial = {rem_q, quo_q[COORD_BITS]};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				cnt_q <= CBITS'(NBITS);
			end else if (run_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CBITS'(1)) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num;
		end else if (run_q) begin
			if (trial >= {1'b0, den}) begin
				rem_q <= COORD_BITS'(trial - {1'b0, den});
				quo_q <= {quo_q[COORD_BITS-1:0], 1'b1};
			end else begin
				rem_q <= trial[COORD_BITS-1:0];
				quo_q <= {quo_q[COORD_BITS-1:0], 1'b0};
			end
		end
	end

	assign done = done_q;
	assign quo  = quo_q;
endmodule
`default_nettype wire

### rtl/core/skyline_rect_packer_core.sv
// skyline rectangle packer: control sequencer around the edge store
// zero-size rectangles give their result word in the cycle after start; others first round
//   the width up with the divider, then walk the skyline edges under each candidate start
//   (quadratic in the edge count), then move the kept edges of the skyline
// throughput: one rectangle at a time; start is accepted only while the sequencer is idle
// reset: canvas 256x256, align step 1, bottom-left mode, skyline of one edge at origin
// the result word is shown for one cycle with done; the receiver cannot stall it
`default_nettype none
`include "skyline_rect_packer_core_macros.svh"
module skyline_rect_packer_core
	import skyrp_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	// command side
	input  wire logic                  start,
	output logic                       busy,
	input  wire logic                  start_new,
	input  wire logic [COORD_BITS-1:0] rect_width,
	input  wire logic [COORD_BITS-1:0] rect_height,
	// result side
	output logic                       done,
	output logic [COORD_BITS-1:0]      pos_x,
	output logic [COORD_BITS-1:0]      pos_y,
	output logic                       placed,
	output logic                       all_placed,
	// configuration
	input  wire logic                  cfg_we,
	input  wire logic [1:0]            cfg_idx,
	input  wire logic [COORD_BITS-1:0] cfg_wdata
);
	localparam int CW = COORD_BITS;
	localparam int EW = CW + 10;        // extent accumulator
	localparam int MW = CW + 2;         // height difference
	localparam int PW = EW + MW;        // product
	localparam int WW = PW + 16;        // waste sum

	typedef enum logic [21:0] {
		ST_IDLE    = 22'd1 << 0,
		ST_DIV     = 22'd1 << 1,
		ST_MUL     = 22'd1 << 2,
		ST_CHK     = 22'd1 << 3,
		ST_S1_RD   = 22'd1 << 4,
		ST_S1_CK   = 22'd1 << 5,
		ST_S2_RDT  = 22'd1 << 6,
		ST_S2_CKT  = 22'd1 << 7,
		ST_S2_RDN  = 22'd1 << 8,
		ST_S2_CKN  = 22'd1 << 9,
		ST_LY_RD0  = 22'd1 << 10,
		ST_LY_RD1  = 22'd1 << 11,
		ST_LY_CALC = 22'd1 << 12,
		ST_LY_ACC  = 22'd1 << 13,
		ST_LY_END  = 22'd1 << 14,
		ST_FIN     = 22'd1 << 15,
		ST_U_RD    = 22'd1 << 16,
		ST_U_CK    = 22'd1 << 17,
		ST_CP_SET  = 22'd1 << 18,
		ST_CP_RD   = 22'd1 << 19,
		ST_CP_WR   = 22'd1 << 20,
		ST_WR_NEW  = 22'd1 << 21
	} state_t;

	typedef enum logic {RET_S1, RET_S2} ret_t;

	state_t state_q;
	ret_t   ret_q;

	// configuration registers
	logic [CW-1:0] canvas_w_q, canvas_h_q, align_q;
	logic          mode_q;
	logic [CW-1:0] al;

	// item registers
	logic [CW-1:0]        w_q, h_q, aw_q;
	logic [2*CW:0]        awfull_q;
	logic [IDX_BITS-1:0]  count_q;
	logic                 allfit_q;

	// scan indexes
	logic [IDX_BITS-1:0]  i_q, t_q, nd_q;
	logic [CW-1:0]        x2_q;

	// lowest-y walk
	logic [IDX_BITS-1:0]  ly_i_q, ly_f_q;
	logic [CW-1:0]        ly_x0_q, ly_y_q, ly_fx_q, cur_x_q, cur_y_q;
	logic                 ly_first_q;
	logic signed [EW-1:0] ly_ext_q;
	logic signed [WW-1:0] ly_ws_q;
	logic signed [PW-1:0] prod_q;

	// best candidate so far
	logic                 have_q;
	logic [CW-1:0]        ty_q, tx_q, selx_q;
	logic signed [WW-1:0] best_q;
	logic [IDX_BITS-1:0]  sel_q;

	// skyline update
	logic [IDX_BITS-1:0]  p_q, c_q, src_q, dst_q, newcnt_q;
	logic [CW:0]          end_q;
	logic                 right_q;

	// result word
	logic                 done_q, placed_q, allp_q;
	logic [CW-1:0]        pos_x_q, pos_y_q;

	mem_req_t             mreq;
	edge_t                rd;
	logic                 div_start, div_done;
	logic [CW:0]          div_quo;
	logic                 accept;

	assign al     = (align_q == '0) ? CW'(1) : align_q;
	assign accept = start && (state_q == ST_IDLE);
	assign div_start = accept && rect_width != '0 && rect_height != '0;

	skyrp_mem u_mem (
		.clk     (clk),
		.arst_n  (arst_n),
		.req     (mreq),
		.rd_data (rd)
	);

	skyrp_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    ({1'b0, rect_width} + {1'b0, al} - 1'b1),
		.den    (al),
		.done   (div_done),
		.quo    (div_quo)
	);

	// index helpers
	logic [IDX_BITS-1:0] ly_ip1, nd_p1, c_p1;
	assign ly_ip1 = ly_i_q + 1'b1;
	assign nd_p1  = nd_q + 1'b1;
	assign c_p1   = c_q + 1'b1;

	// x of the next edge, or the canvas end mark past the list
	logic [CW:0] rdx_or_w_ly, rdx_or_w_t, rdx_or_w_nd, rdx_or_w_c;
	assign rdx_or_w_ly = (ly_ip1 < count_q) ? {1'b0, rd.x} : {1'b0, canvas_w_q};
	assign rdx_or_w_t  = (t_q < count_q)    ? {1'b0, rd.x} : {1'b0, canvas_w_q};
	assign rdx_or_w_nd = (nd_p1 < count_q)  ? {1'b0, rd.x} : {1'b0, canvas_w_q};
	assign rdx_or_w_c  = (c_p1 < count_q)   ? {1'b0, rd.x} : {1'b0, canvas_w_q};

	// one step of the lowest-y walk
	logic signed [EW-1:0] nx_s, cx_s, x0_s, aw_s, d_s, ma, ext_n;
	logic signed [MW-1:0] mb;
	logic signed [PW-1:0] prod_c;
	logic                 rise;

	always_comb begin
		nx_s = EW'(signed'({1'b0, rdx_or_w_ly}));
		cx_s = EW'(signed'({1'b0, cur_x_q}));
		x0_s = EW'(signed'({1'b0, ly_x0_q}));
		aw_s = EW'(signed'({1'b0, aw_q}));
		rise = cur_y_q > ly_y_q;
		d_s  = nx_s - cx_s;
		if (rise) begin
			ma    = ly_ext_q;
			mb    = signed'({2'b00, cur_y_q}) - signed'({2'b00, ly_y_q});
			ext_n = ly_ext_q + ((cx_s < x0_s) ? (nx_s - x0_s) : (nx_s - cx_s));
		end else begin
			if (d_s + ly_ext_q > aw_s) begin
				d_s = aw_s - ly_ext_q;
			end
			ma    = d_s;
			mb    = signed'({2'b00, ly_y_q}) - signed'({2'b00, cur_y_q});
			ext_n = ly_ext_q + d_s;
		end
		prod_c = ma * mb;
	end

	// candidate compare at the end of a walk
	logic [CW:0] hy;
	logic        fits, take1, take2;
	assign hy    = {1'b0, h_q} + {1'b0, ly_y_q};
	assign fits  = hy <= {1'b0, canvas_h_q};
	assign take1 = mode_q ? (fits && (!have_q || ly_y_q < ty_q ||
	                         (ly_y_q == ty_q && ly_ws_q < best_q)))
	                      : (!have_q || ly_y_q < ty_q);
	assign take2 = fits && (!have_q || ly_y_q < ty_q || (ly_y_q == ty_q &&
	               (ly_ws_q < best_q || (ly_ws_q == best_q && ly_x0_q < tx_q))));

	// placement test and new top of the placed rectangle
	logic [CW:0] tyh;
	logic        ok;
	assign tyh = {1'b0, ty_q} + {1'b0, h_q};
	assign ok  = have_q && tyh <= {1'b0, canvas_h_q} && count_q < IDX_BITS'(MAX_NODES);

	// edge store port
	always_comb begin
		mreq = '0;
		unique case (state_q)
			ST_IDLE: begin
				mreq.clr = accept && start_new;
			end
			ST_S1_RD: begin
				mreq.rd_en   = i_q < count_q;
				mreq.rd_addr = i_q[ADDR_BITS-1:0];
			end
			ST_S2_RDT: begin
				mreq.rd_en   = t_q < count_q;
				mreq.rd_addr = t_q[ADDR_BITS-1:0];
			end
			ST_S2_RDN: begin
				mreq.rd_en   = nd_p1 < count_q;
				mreq.rd_addr = nd_p1[ADDR_BITS-1:0];
			end
			ST_LY_RD0: begin
				mreq.rd_en   = ly_i_q < count_q;
				mreq.rd_addr = ly_i_q[ADDR_BITS-1:0];
			end
			ST_LY_RD1: begin
				mreq.rd_en   = ly_ip1 < count_q;
				mreq.rd_addr = ly_ip1[ADDR_BITS-1:0];
			end
			ST_U_RD: begin
				mreq.rd_en   = c_p1 < count_q;
				mreq.rd_addr = c_p1[ADDR_BITS-1:0];
			end
			ST_CP_RD: begin
				mreq.rd_en   = 1'b1;
				mreq.rd_addr = src_q[ADDR_BITS-1:0];
			end
			ST_CP_WR: begin
				mreq.wr_en     = 1'b1;
				mreq.wr_addr   = dst_q[ADDR_BITS-1:0];
				mreq.wr_data.y = rd.y;
				// the first kept edge is cut back to the right side of the rectangle
				mreq.wr_data.x = (src_q == c_q && {1'b0, rd.x} < end_q) ?
				                 end_q[CW-1:0] : rd.x;
			end
			ST_WR_NEW: begin
				mreq.wr_en     = 1'b1;
				mreq.wr_addr   = p_q[ADDR_BITS-1:0];
				mreq.wr_data.x = tx_q;
				mreq.wr_data.y = tyh[CW-1:0];
			end
			default: begin
				mreq = '0;
			end
		endcase
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			canvas_w_q <= CW'(256);
			canvas_h_q <= CW'(256);
			align_q    <= CW'(1);
			mode_q     <= 1'b0;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_idx))
				REG_CANVAS_W: canvas_w_q <= cfg_wdata;
				REG_CANVAS_H: canvas_h_q <= cfg_wdata;
				REG_ALIGN:    align_q    <= cfg_wdata;
				REG_MODE:     mode_q     <= cfg_wdata[0];
				default:      mode_q     <= mode_q;
			endcase
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			count_q  <= IDX_BITS'(1);
			allfit_q <= 1'b1;
			done_q   <= 1'b0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						w_q <= rect_width;
						h_q <= rect_height;
						if (start_new) begin
							count_q  <= IDX_BITS'(1);
							allfit_q <= 1'b1;
						end
						if (rect_width == '0 || rect_height == '0) begin
							// zero size goes to the origin and always counts as placed
							done_q   <= 1'b1;
							pos_x_q  <= '0;
							pos_y_q  <= '0;
							placed_q <= 1'b1;
							allp_q   <= start_new || allfit_q;
						end else begin
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_done) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					awfull_q <= div_quo * al;
					state_q  <= ST_CHK;
				end
				ST_CHK: begin
					have_q <= 1'b0;
					i_q    <= '0;
					aw_q   <= awfull_q[CW-1:0];
					if (awfull_q <= (2*CW+1)'(canvas_w_q) && h_q <= canvas_h_q) begin
						state_q <= ST_S1_RD;
					end else begin
						state_q <= ST_FIN;
					end
				end
				// left-aligned starts
				ST_S1_RD: begin
					state_q <= (i_q < count_q) ? ST_S1_CK :
					           (mode_q ? ST_S2_RDT : ST_FIN);
					t_q  <= '0;
					nd_q <= '0;
				end
				ST_S1_CK: begin
					if ({1'b0, aw_q} + {1'b0, rd.x} <= {1'b0, canvas_w_q}) begin
						ly_i_q     <= i_q;
						ly_f_q     <= i_q;
						ly_x0_q    <= rd.x;
						ly_y_q     <= '0;
						ly_ext_q   <= '0;
						ly_ws_q    <= '0;
						ly_first_q <= 1'b1;
						ret_q      <= RET_S1;
						state_q    <= ST_LY_RD0;
					end else begin
						state_q <= mode_q ? ST_S2_RDT : ST_FIN;
					end
				end
				// right-aligned starts, best-fit only
				ST_S2_RDT: begin
					state_q <= (t_q <= count_q) ? ST_S2_CKT : ST_FIN;
				end
				ST_S2_CKT: begin
					if (rdx_or_w_t < {1'b0, aw_q}) begin
						t_q     <= t_q + 1'b1;
						state_q <= ST_S2_RDT;
					end else begin
						x2_q    <= CW'(rdx_or_w_t - {1'b0, aw_q});
						state_q <= ST_S2_RDN;
					end
				end
				ST_S2_RDN: begin
					if (nd_p1 <= count_q) begin
						state_q <= ST_S2_CKN;
					end else begin
						t_q     <= t_q + 1'b1;
						state_q <= ST_S2_RDT;
					end
				end
				ST_S2_CKN: begin
					if (rdx_or_w_nd <= {1'b0, x2_q}) begin
						nd_q    <= nd_p1;
						state_q <= ST_S2_RDN;
					end else begin
						ly_i_q     <= nd_q;
						ly_f_q     <= nd_q;
						ly_x0_q    <= x2_q;
						ly_y_q     <= '0;
						ly_ext_q   <= '0;
						ly_ws_q    <= '0;
						ly_first_q <= 1'b1;
						ret_q      <= RET_S2;
						state_q    <= ST_LY_RD0;
					end
				end
				// lowest y and waste under a span
				ST_LY_RD0: begin
					state_q <= (ly_i_q < count_q) ? ST_LY_RD1 : ST_LY_END;
				end
				ST_LY_RD1: begin
					cur_x_q    <= rd.x;
					cur_y_q    <= rd.y;
					ly_first_q <= 1'b0;
					if (ly_first_q) begin
						ly_fx_q <= rd.x;
					end
					state_q <= ({1'b0, rd.x} < {1'b0, ly_x0_q} + {1'b0, aw_q}) ?
					           ST_LY_CALC : ST_LY_END;
				end
				ST_LY_CALC: begin
					prod_q   <= prod_c;
					ly_ext_q <= ext_n;
					if (rise) begin
						ly_y_q <= cur_y_q;
					end
					ly_i_q  <= ly_ip1;
					state_q <= ST_LY_ACC;
				end
				ST_LY_ACC: begin
					ly_ws_q <= ly_ws_q + WW'(prod_q);
					state_q <= ST_LY_RD0;
				end
				ST_LY_END: begin
					if (ret_q == RET_S1) begin
						if (take1) begin
							have_q <= 1'b1;
							ty_q   <= ly_y_q;
							tx_q   <= ly_x0_q;
							best_q <= ly_ws_q;
							sel_q  <= ly_f_q;
							selx_q <= ly_fx_q;
						end
						i_q     <= i_q + 1'b1;
						state_q <= ST_S1_RD;
					end else begin
						if (take2) begin
							have_q <= 1'b1;
							ty_q   <= ly_y_q;
							tx_q   <= ly_x0_q;
							best_q <= ly_ws_q;
							sel_q  <= ly_f_q;
							selx_q <= ly_fx_q;
						end
						t_q     <= t_q + 1'b1;
						state_q <= ST_S2_RDT;
					end
				end
				ST_FIN: begin
					if (ok) begin
						end_q   <= {1'b0, tx_q} + {1'b0, w_q};
						p_q     <= (selx_q >= tx_q) ? sel_q : sel_q + 1'b1;
						c_q     <= (selx_q >= tx_q) ? sel_q : sel_q + 1'b1;
						state_q <= ST_U_RD;
					end else begin
						allfit_q <= 1'b0;
						done_q   <= 1'b1;
						pos_x_q  <= '0;
						pos_y_q  <= '0;
						placed_q <= 1'b0;
						allp_q   <= 1'b0;
						state_q  <= ST_IDLE;
					end
				end
				// find the first edge that stays visible right of the rectangle
				ST_U_RD: begin
					state_q <= (c_q < count_q) ? ST_U_CK : ST_CP_SET;
				end
				ST_U_CK: begin
					if (rdx_or_w_c <= end_q) begin
						c_q     <= c_p1;
						state_q <= ST_U_RD;
					end else begin
						state_q <= ST_CP_SET;
					end
				end
				// move the kept tail so it follows the new edge
				ST_CP_SET: begin
					newcnt_q <= p_q + 1'b1 + count_q - c_q;
					right_q  <= (c_q == p_q);
					if (c_q == p_q) begin
						src_q <= count_q - 1'b1;
						dst_q <= count_q;
					end else begin
						src_q <= c_q;
						dst_q <= p_q + 1'b1;
					end
					state_q <= (count_q == c_q) ? ST_WR_NEW : ST_CP_RD;
				end
				ST_CP_RD: begin
					state_q <= ST_CP_WR;
				end
				ST_CP_WR: begin
					if (right_q) begin
						src_q   <= src_q - 1'b1;
						dst_q   <= dst_q - 1'b1;
						state_q <= (src_q == c_q) ? ST_WR_NEW : ST_CP_RD;
					end else begin
						src_q   <= src_q + 1'b1;
						dst_q   <= dst_q + 1'b1;
						state_q <= (src_q == count_q - 1'b1) ? ST_WR_NEW : ST_CP_RD;
					end
				end
				ST_WR_NEW: begin
					count_q  <= newcnt_q;
					done_q   <= 1'b1;
					pos_x_q  <= tx_q;
					pos_y_q  <= ty_q;
					placed_q <= 1'b1;
					allp_q   <= allfit_q;
					state_q  <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy       = (state_q != ST_IDLE);
	assign done       = done_q;
	assign pos_x      = pos_x_q;
	assign pos_y      = pos_y_q;
	assign placed     = placed_q;
	assign all_placed = allp_q;

	`SKYRP_IMPLY(a_done_idle, done, !busy, "result word shown while sequencer busy")
	`SKYRP_NEXT(a_start_resp, start && !busy, busy || done, "accepted word dropped")
	`SKYRP_IMPLY(a_fail_flag, done && !placed, !all_placed, "failure kept all_placed high")
	`SKYRP_CHECK(a_count_range, count_q != '0 && count_q <= IDX_BITS'(MAX_NODES),
		"edge count out of range")
endmodule
`default_nettype wire
